// ----- design/izw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izw_pkg
// Shared types and token codes for the integer to word token converter.
// ----------------------------------------------------------------------------
package izw_pkg;

  localparam int NUM_W   = 31;  // width of the input number
  localparam int WORD_W  = 5;   // width of a word token
  localparam int DIGITS  = 10;  // decimal digits needed for 2^31-1
  localparam int BIN_W   = 32;  // number padded to an even bit count
  localparam int STEPS   = BIN_W / 2;  // two bits enter the digit chain per cycle
  localparam int STEP_W  = $clog2(STEPS);
  localparam int SLOTS   = 20;  // four groups of five word slots

  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0]        digit_t;

  localparam word_t TOK_ZERO     = 5'd0;
  localparam word_t TOK_TEN      = 5'd10;
  localparam word_t TOK_TENS_OFS = 5'd18;
  localparam word_t TOK_HUNDRED  = 5'd28;
  localparam word_t TOK_THOUSAND = 5'd29;
  localparam word_t TOK_MILLION  = 5'd30;
  localparam word_t TOK_BILLION  = 5'd31;

  // Controls shared by all digit cells.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  // Finished conversion handed from the converter to the word sequencer.
  typedef struct packed {
    logic               done;
    digit_t [DIGITS-1:0] digits;
  } conv_res_t;

endpackage

// ----- design/izw_num_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izw_num_if
// Valid/ready channel that carries one number.
// ----------------------------------------------------------------------------
interface izw_num_if;
  logic          valid;
  logic          ready;
  izw_pkg::num_t number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// ----- design/izw_word_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izw_word_if
// Valid/ready channel that carries one word token and its last flag.
// ----------------------------------------------------------------------------
interface izw_word_if;
  logic           valid;
  logic           ready;
  izw_pkg::word_t word;
  logic           last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink   (input valid, input word, input last_word, output ready);
endinterface

// ----- design/izw_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izw_cell
// One BCD digit of the binary to decimal chain: two add-3 and shift steps
// per cycle, taking its incoming bits from the next lower digit.
// ----------------------------------------------------------------------------
module izw_cell (
  input  logic               clk,
  input  izw_pkg::cell_ctl_t ctl,
  input  logic               cin_hi,
  input  logic               cin_lo,
  output logic               cout_hi,
  output logic               cout_lo,
  output izw_pkg::digit_t    digit
);
  import izw_pkg::*;

  function automatic digit_t adj3(input digit_t d);
    adj3 = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  digit_t first;
  digit_t mid;
  digit_t second;
  digit_t digit_next;

  always_comb begin
    first      = adj3(digit);
    mid        = {first[2:0], cin_hi};
    second     = adj3(mid);
    digit_next = {second[2:0], cin_lo};
    cout_hi    = first[3];
    cout_lo    = second[3];
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.shift) begin
      digit <= digit_next;
    end
  end

endmodule

// ----- design/izw_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izw_conv
// Binary to decimal converter: a row of digit cells fed two bits a cycle
// from a shift register.
// ----------------------------------------------------------------------------
module izw_conv (
  input  logic               clk,
  input  logic               rst,
  izw_num_if.sink            nums,
  input  logic               take,
  output izw_pkg::conv_res_t res
);
  import izw_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [BIN_W-1:0]  bin;
  logic              accept;
  cell_ctl_t         ctl;
  logic [DIGITS-1:0] carry_hi;
  logic [DIGITS-1:0] carry_lo;
  digit_t [DIGITS-1:0] digits;

  assign nums.ready = !rst && !busy && (!done || take);
  assign accept     = nums.valid && nums.ready;
  assign ctl.clear  = accept;
  assign ctl.shift  = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (done && take) begin
        done <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin <= {{(BIN_W - NUM_W){1'b0}}, nums.number};
    end else if (busy) begin
      bin <= {bin[BIN_W-3:0], 2'b00};
    end
  end

  genvar k;
  generate
    for (k = 0; k < DIGITS; k++) begin : g_cell
      if (k == 0) begin : g_first
        izw_cell u_cell (
          .clk    (clk),
          .ctl    (ctl),
          .cin_hi (bin[BIN_W-1]),
          .cin_lo (bin[BIN_W-2]),
          .cout_hi(carry_hi[k]),
          .cout_lo(carry_lo[k]),
          .digit  (digits[k])
        );
      end else begin : g_next
        izw_cell u_cell (
          .clk    (clk),
          .ctl    (ctl),
          .cin_hi (carry_hi[k-1]),
          .cin_lo (carry_lo[k-1]),
          .cout_hi(carry_hi[k]),
          .cout_lo(carry_lo[k]),
          .digit  (digits[k])
        );
      end
    end
  endgenerate

  assign res.done   = done;
  assign res.digits = digits;

endmodule

// ----- design/izw_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izw_emit
// Word sequencer: lays the decimal digits out as word slots and sends the
// valid slots in order via an output register, one word per unstalled cycle.
// ----------------------------------------------------------------------------
module izw_emit (
  input  logic               clk,
  input  logic               rst,
  input  izw_pkg::conv_res_t res,
  output logic               take,
  izw_word_if.source         words
);
  import izw_pkg::*;

  typedef struct packed {
    logic  [4:0] valid;
    word_t [4:0] tok;
  } grp_t;

  // Slots of one group: hundreds digit, Hundred, low-digit, teen or tens
  // word, ones word, scale word.
  function automatic grp_t group_slots(input digit_t h, input digit_t t,
                                       input digit_t o, input word_t scale,
                                       input logic has_scale,
                                       input logic force_zero);
    grp_t   g;
    logic   nz_h;
    logic   nz_low;
    g.valid  = '0;
    g.tok    = '0;
    nz_h     = (h != 4'd0);
    nz_low   = (t != 4'd0) || (o != 4'd0);
    g.valid[0] = nz_h;
    g.tok[0]   = {1'b0, h};
    g.valid[1] = nz_h;
    g.tok[1]   = TOK_HUNDRED;
    // Below twenty the two low digits name a single word.
    g.valid[2] = nz_low || force_zero;
    if (t >= 4'd2) begin
      g.tok[2] = TOK_TENS_OFS + {1'b0, t};
    end else if (t[0]) begin
      g.tok[2] = TOK_TEN + {1'b0, o};
    end else begin
      g.tok[2] = {1'b0, o};
    end
    g.valid[3] = (t >= 4'd2) && (o != 4'd0);
    g.tok[3]   = {1'b0, o};
    g.valid[4] = has_scale && (nz_h || nz_low);
    g.tok[4]   = scale;
    group_slots = g;
  endfunction

  grp_t               g0;
  grp_t               g1;
  grp_t               g2;
  grp_t               g3;
  logic               all_zero;
  logic [SLOTS-1:0]   mask_load;
  word_t [SLOTS-1:0]  tok_load;
  logic [SLOTS-1:0]   mask;
  word_t [SLOTS-1:0]  tok;
  logic [SLOTS-1:0]   sel;
  logic [SLOTS-1:0]   left;
  logic [SLOTS-1:0]   rem;
  logic [SLOTS-1:0]   mask_next;
  logic               pop;
  word_t              sel_tok;

  always_comb begin
    all_zero  = (res.digits == '0);
    g0 = group_slots(4'd0, 4'd0, res.digits[9], TOK_BILLION, 1'b1, 1'b0);
    g1 = group_slots(res.digits[8], res.digits[7], res.digits[6],
                     TOK_MILLION, 1'b1, 1'b0);
    g2 = group_slots(res.digits[5], res.digits[4], res.digits[3],
                     TOK_THOUSAND, 1'b1, 1'b0);
    g3 = group_slots(res.digits[2], res.digits[1], res.digits[0],
                     TOK_ZERO, 1'b0, all_zero);
    mask_load = {g3.valid, g2.valid, g1.valid, g0.valid};
    tok_load  = {g3.tok, g2.tok, g1.tok, g0.tok};
  end

  always_comb begin
    sel     = mask & (~mask + 1'b1);
    left    = mask & ~sel;
    pop     = (|mask) && (!words.valid || words.ready);
    rem     = pop ? left : mask;
    take    = res.done && (rem == '0);
    mask_next = take ? mask_load : rem;
    sel_tok = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel_tok = sel_tok | (sel[i] ? tok[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask        <= '0;
      words.valid <= 1'b0;
    end else begin
      mask <= mask_next;
      if (pop) begin
        words.valid <= 1'b1;
      end else if (words.ready) begin
        words.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok <= tok_load;
    end
    if (pop) begin
      words.word      <= sel_tok;
      words.last_word <= (left == '0);
    end
  end

endmodule

// ----- design/integer_to_word_tokens.sv -----
`timescale 1ns / 1ps
// An accepted number passes the digit chain, done flag, slot mask and output
// register to its first word. Words then leave one per cycle while the sink
// takes them, 1 to 16 per number. The digit chain converts the next number
// while the sequencer sends the previous number's words; a stalled sink
// holds off the next number. Reset (rst, synchronous) empties the converter,
// the sequencer and the output, and no number is taken while it is high.
// ----------------------------------------------------------------------------
// integer_to_word_tokens
// Spells a 31-bit number as English word tokens, in reading order.
// ----------------------------------------------------------------------------
module integer_to_word_tokens (
  input  logic       clk,
  input  logic       rst,
  izw_num_if.sink    nums,
  izw_word_if.source words
);
  import izw_pkg::*;

  conv_res_t res;
  logic      take;

  izw_conv u_conv (
    .clk (clk),
    .rst (rst),
    .nums(nums),
    .take(take),
    .res (res)
  );

  izw_emit u_emit (
    .clk  (clk),
    .rst  (rst),
    .res  (res),
    .take (take),
    .words(words)
  );

endmodule

// ----- design/izw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izw_checker
// Port-level checks for the integer to word token converter, bound to the
// top level.
// ----------------------------------------------------------------------------
module izw_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input izw_pkg::word_t out_word,
  input logic           out_last
);
  import izw_pkg::*;

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("stalled word changed");

  // The digit chain is busy right after a number enters.
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("number accepted while converting");

  // It is still busy on the second-to-last conversion cycle.
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##15 !in_ready)
    else $error("conversion ended early");

  // Zero is only ever spoken alone.
  a_zero_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word == TOK_ZERO) |-> out_last)
    else $error("Zero word not last");

endmodule

bind integer_to_word_tokens izw_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (nums.valid),
  .in_ready (nums.ready),
  .out_valid(words.valid),
  .out_ready(words.ready),
  .out_word (words.word),
  .out_last (words.last_word)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the number to word token converter against its own spelling.
// Numbers go in over the number channel with random gaps. The words that
// come out are compared, token and last flag, with words spelled here from
// each accepted number. Directed numbers cover the group and teen edges.
// Random numbers then follow: full-range values, group-built values and
// small values. Both channels stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
  import izw_pkg::*;

  typedef struct {
    word_t word;
    logic  last_word;
  } spoken_t;

  logic clk;
  logic rst;

  izw_num_if  nums ();
  izw_word_if words ();

  integer_to_word_tokens dut (
    .clk   (clk),
    .rst   (rst),
    .nums  (nums),
    .words (words)
  );

  spoken_t spoken_q[$];
  int      errors;
  bit      calm;
  int      ready_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Most gaps and stalls are short; a few are long enough to back up the block.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Spells one number and queues its words in reading order.
  function automatic void spell_number(input num_t n);
    word_t       scale_tok [4];
    word_t       toks[$];
    int unsigned v;
    int unsigned grp [4];
    int unsigned g;
    int unsigned hund;
    int unsigned low;
    spoken_t     s;
    scale_tok = '{TOK_BILLION, TOK_MILLION, TOK_THOUSAND, TOK_ZERO};
    v = 32'(n);
    grp[0] = (v / 1000000000) % 1000;
    grp[1] = (v / 1000000) % 1000;
    grp[2] = (v / 1000) % 1000;
    grp[3] = v % 1000;
    if (v == 0) begin
      toks.push_back(TOK_ZERO);
    end else begin
      for (int i = 0; i < 4; i++) begin
        g = grp[i];
        if (g == 0) continue;
        hund = g / 100;
        low  = g % 100;
        if (hund != 0) begin
          toks.push_back(word_t'(hund));
          toks.push_back(TOK_HUNDRED);
        end
        if (low != 0) begin
          if (low <= 19) begin
            toks.push_back(word_t'(low));
          end else begin
            toks.push_back(TOK_TENS_OFS + word_t'(low / 10));
            if (low % 10 != 0) toks.push_back(word_t'(low % 10));
          end
        end
        if (i < 3) toks.push_back(scale_tok[i]);
      end
    end
    foreach (toks[i]) begin
      s.word      = toks[i];
      s.last_word = (i == toks.size() - 1);
      spoken_q.push_back(s);
    end
  endfunction

  // Sends one number; valid stays high across back-to-back numbers.
  task automatic send_number(input num_t n);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 40) gap = pick_idle_len();
    if (gap > 0) begin
      nums.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    nums.valid  <= 1'b1;
    nums.number <= n;
    do @(posedge clk); while (!nums.ready);
    spell_number(n);
  endtask

  // Holds the sender until every spelled word has come out.
  task automatic wait_all_spoken();
    nums.valid <= 1'b0;
    while (spoken_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic int unsigned pick_group_value();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(1, 19);
      2: return 10 * $urandom_range(2, 9);
      3: return 100 * $urandom_range(1, 9);
      4: return 100 * $urandom_range(1, 9) + $urandom_range(1, 19);
      5: return $urandom_range(100, 999);
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  function automatic num_t build_grouped_number();
    longint unsigned v;
    v = longint'($urandom_range(0, 2)) * 1000000000 +
        longint'(pick_group_value()) * 1000000 +
        longint'(pick_group_value()) * 1000 +
        longint'(pick_group_value());
    if (v > 64'd2147483647) v -= 1000000000;
    return num_t'(v);
  endfunction

  task automatic test_directed();
    num_t picks[$];
    picks = '{31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd19, 31'd20, 31'd21, 31'd90,
              31'd99, 31'd100, 31'd101, 31'd110, 31'd119, 31'd999, 31'd1000,
              31'd1000001, 31'd1000000, 31'd1000000000, 31'd2000000000,
              31'd1777777777, 31'd2147483647, 31'd1010010};
    foreach (picks[i]) send_number(picks[i]);
    wait_all_spoken();
  endtask

  task automatic test_full_range();
    repeat (60) send_number(num_t'($urandom));
    wait_all_spoken();
  endtask

  task automatic test_grouped_numbers();
    for (int i = 0; i < 160; i++) begin
      send_number(build_grouped_number());
      if (i % 40 == 39) wait_all_spoken();
    end
    wait_all_spoken();
  endtask

  // Runs with no gaps and no stalls, so the block goes at its full rate.
  task automatic test_small_full_rate();
    calm = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) begin
        send_number(num_t'($urandom_range(0, 999)));
      end else begin
        send_number(num_t'(build_grouped_number() % 1000000));
      end
    end
    calm = 1'b0;
    wait_all_spoken();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      words.ready <= 1'b0;
      ready_stall = 0;
    end else if (ready_stall > 0) begin
      ready_stall--;
      words.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      ready_stall = pick_idle_len() - 1;
      words.ready <= 1'b0;
    end else begin
      words.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    spoken_t want;
    if (!rst && words.valid && words.ready) begin
      if (spoken_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d last %0b",
                                  words.word, words.last_word));
      end else begin
        want = spoken_q.pop_front();
        if (words.word !== want.word) begin
          report_mismatch($sformatf("word %0d, expected %0d", words.word, want.word));
        end
        if (words.last_word !== want.last_word) begin
          report_mismatch($sformatf("last flag %0b, expected %0b on word %0d",
                                    words.last_word, want.last_word, want.word));
        end
      end
    end
  end

  initial begin
    errors = 0;
    calm   = 1'b0;
    rst         <= 1'b1;
    nums.valid  <= 1'b0;
    nums.number <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_range();
    test_grouped_numbers();
    test_small_full_rate();
    wait_all_spoken();
    if (errors == 0 && spoken_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
